FILE: sv/dq_pkg.sv
package dq_pkg;

    localparam int CMD_W     = 3;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: sv/dq_if.sv
interface dq_req_if import dq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] popped_value;
    logic [CNT_OUT_W-1:0]    match_count;
    logic [CNT_OUT_W-1:0]    length;

    modport source (output valid, output status, output popped_value, output match_count,
                    output length, input ready);
    modport sink   (input valid, input status, input popped_value, input match_count,
                    input length, output ready);
endinterface

FILE: sv/dq_mem.sv
module dq_mem import dq_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/int_deque_with_search.sv
// Push writes memory, then S_EMIT. Pop: registered memory read, then S_POP and S_EMIT.
// Search: S_SEARCH, one memory read per entry through a single read port, then S_EMIT.
// Throughput: one item at a time; the next item is taken once the result sits
// in the output register, which holds it until taken.
// Reset: rst_n asynchronous, active low; clears head, count, FSM and output registers.
// Entry memory is not cleared; only written entries are ever read.
module int_deque_with_search import dq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int XW = CW + CNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [IW-1:0]           head_reg, head_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [IW-1:0]           ptr_reg, ptr_next;
    logic [CW-1:0]           left_reg, left_next;
    logic [CW-1:0]           match_reg, match_next;
    logic [VAL_W-1:0]        key_reg, key_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic [VAL_W-1:0]        popped_reg, popped_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]       rsp_status_reg, rsp_status_next;
    logic [VAL_W-1:0]        rsp_popped_reg, rsp_popped_next;
    logic [CNT_OUT_W-1:0]    rsp_match_reg, rsp_match_next;
    logic [CNT_OUT_W-1:0]    rsp_length_reg, rsp_length_next;

    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;
    logic [VAL_W-1:0]        mem_rdata;

    logic                    full;
    logic                    empty;
    logic [IW-1:0]           head_inc;
    logic [IW-1:0]           head_dec;
    logic [IW-1:0]           ptr_inc;
    logic [IW-1:0]           back_slot;
    logic [IW-1:0]           last_slot;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        logic [IW-1:0] r;
        if (idx == IW'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] to_out(input logic [CW-1:0] x);
        logic [XW-1:0] w;
        w = XW'(x);
        return w[CNT_OUT_W-1:0];
    endfunction

    assign full      = (cnt_reg == CW'(CAPACITY));
    assign empty     = (cnt_reg == '0);
    assign head_inc  = idx_inc(head_reg);
    assign head_dec  = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - 1'b1;
    assign ptr_inc   = idx_inc(ptr_reg);
    assign back_slot = slot_add(head_reg, cnt_reg);
    assign last_slot = slot_add(head_reg, cnt_reg - 1'b1);

    dq_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        match_next      = match_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        popped_next     = popped_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_popped_next = rsp_popped_reg;
        rsp_match_next  = rsp_match_reg;
        rsp_length_next = rsp_length_reg;
        mem_we          = 1'b0;
        mem_waddr       = back_slot;
        mem_wdata       = req.value;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next    = req.value;
                    status_next = ST_OK;
                    popped_next = '0;
                    match_next  = '0;
                    state_next  = S_EMIT;
                    case (req.cmd)
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = head_dec;
                                head_next = head_dec;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = back_slot;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                head_next  = head_inc;
                                cnt_next   = cnt_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = last_slot;
                                cnt_next   = cnt_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (!empty)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                ptr_next   = head_inc;
                                left_next  = cnt_reg - 1'b1;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                popped_next = mem_rdata;
                state_next  = S_EMIT;
            end
            S_SEARCH:
            begin
                if (mem_rdata == key_reg)
                begin
                    match_next = match_reg + 1'b1;
                end
                if (left_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg;
                    ptr_next  = ptr_inc;
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_popped_next = popped_reg;
                    rsp_match_next  = to_out(match_reg);
                    rsp_length_next = to_out(cnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            cnt_reg        <= '0;
            ptr_reg        <= '0;
            left_reg       <= '0;
            match_reg      <= '0;
            key_reg        <= '0;
            status_reg     <= ST_OK;
            popped_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_popped_reg <= '0;
            rsp_match_reg  <= '0;
            rsp_length_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            ptr_reg        <= ptr_next;
            left_reg       <= left_next;
            match_reg      <= match_next;
            key_reg        <= key_next;
            status_reg     <= status_next;
            popped_reg     <= popped_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_popped_reg <= rsp_popped_next;
            rsp_match_reg  <= rsp_match_next;
            rsp_length_reg <= rsp_length_next;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.popped_value = rsp_popped_reg;
    assign rsp.match_count  = rsp_match_reg;
    assign rsp.length       = rsp_length_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !full &&
         (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK))
        |=> (cnt_reg == CW'($past(cnt_reg) + 1'b1)))
        else $error("push did not grow the queue");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && empty &&
         (req.cmd == CMD_POP_FRONT || req.cmd == CMD_POP_BACK))
        |=> (cnt_reg == '0 && status_reg == ST_EMPTY))
        else $error("pop on empty queue mishandled");

    a_search_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (left_reg < cnt_reg))
        else $error("search walks past stored entries");
`endif

endmodule
